// ===== src/text_to_integer_parser_macros.svh =====
// Assertion macros for the text-to-integer parser.
// Expects clk and rst_n in the scope of each use.
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define T2I_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("t2i assertion failed");
// next-cycle implication
`define T2I_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("t2i assertion failed");
`else
`define T2I_ASSERT_IMP(lbl, ante, cons)
`define T2I_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/t2i_pkg.sv =====
// Shared types and constants of the text-to-integer parser.
// No dependencies.
package t2i_pkg;

  localparam int CHAR_W   = 8;
  localparam int BASE_W   = 6;
  localparam int DIGIT_W  = 6;
  localparam int ACC_W    = 64;
  localparam int COUNT_W  = 16;
  localparam int DATA_OUT_W = 88;   // 64 + 16 + 1, padded to bytes

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

  localparam int Q_DEPTH = 4;       // power of two
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_RESULT = 2'd2;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;

  // classified character passed from front to back
  typedef struct packed {
    logic               blank;
    logic               sign;
    logic               minus;
    logic               zero;
    logic               is_x;
    logic               dig_ok;
    logic [DIGIT_W-1:0] dig;
  } t2i_tok_t;

  typedef enum logic [2:0] {
    PH_BLANK,
    PH_SIGNED,
    PH_AUTO_ZERO,
    PH_HEX_ZERO,
    PH_DIGITS
  } t2i_phase_t;

endpackage

// ===== src/t2i_front.sv =====
// Front end: takes characters and classifies them into tokens.
// Depends on t2i_pkg.
module t2i_front import t2i_pkg::*; (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,   // [7:0] character
  input  logic              q_full,
  output logic              q_push,
  output t2i_tok_t          q_tok
);

  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] off;

  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_tok        = '0;
    off          = '0;
    q_tok.blank  = (c == CH_SPACE) || (c == CH_TAB);
    q_tok.sign   = (c == CH_PLUS) || (c == CH_MINUS);
    q_tok.minus  = (c == CH_MINUS);
    q_tok.zero   = (c == CH_ZERO);
    q_tok.is_x   = (c == CH_X_LO) || (c == CH_X_UP);
    priority if (c >= CH_ZERO && c <= CH_NINE) begin
      off          = c - CH_ZERO;
      q_tok.dig_ok = 1'b1;
    end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
      off          = c - CH_A_LO + 8'd10;
      q_tok.dig_ok = 1'b1;
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      off          = c - CH_A_UP + 8'd10;
      q_tok.dig_ok = 1'b1;
    end else begin
      q_tok.dig_ok = 1'b0;
    end
    q_tok.dig = off[DIGIT_W-1:0];
  end

endmodule

// ===== src/t2i_queue.sv =====
// Short token queue between the front and back ends.
// Depends on t2i_pkg.
module t2i_queue import t2i_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  t2i_tok_t push_tok,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output t2i_tok_t pop_tok
);

  t2i_tok_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;

  assign full    = (count_r == Q_CW'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign pop_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ===== src/t2i_back.sv =====
// Back end: parse state machine, digit accumulator and result register.
// Depends on t2i_pkg and text_to_integer_parser_macros.svh.
`include "text_to_integer_parser_macros.svh"

module t2i_back import t2i_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [BASE_W-1:0]     cfg_base,
  input  logic                  cfg_signed,
  input  logic                  cfg_wide,
  input  logic                  q_valid,
  input  t2i_tok_t              q_tok,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_OUT_W-1:0] out_tdata
);

  t2i_phase_t          phase_r, phase_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic                seen_r, seen_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]    out_value_r;
  logic [COUNT_W-1:0]  out_consumed_r;
  logic                out_converted_r;

  logic                do_start, do_digit, bump, emit;
  logic [BASE_W-1:0]   dig_base;
  logic                dig_seen;
  logic [ACC_W-1:0]    mac;
  logic [ACC_W-1:0]    fin_val;

  // a token moves on only when the result register is free or draining
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  assign mac = acc_r * ACC_W'(dig_base) + ACC_W'(q_tok.dig);

  always_comb begin
    fin_val = (neg_r && cfg_signed) ? (ACC_W'(0) - acc_r) : acc_r;
    if (!cfg_wide) begin
      fin_val[ACC_W-1:ACC_W/2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BLANK;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      cnt_r   <= '0;
      base_r  <= '0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    seen_nxt  = seen_r;
    do_start  = 1'b0;
    do_digit  = 1'b0;
    bump      = 1'b0;
    emit      = 1'b0;
    dig_base  = base_r;
    dig_seen  = seen_r;

    if (q_pop) begin
      unique case (phase_r)
        PH_BLANK: begin
          if (q_tok.blank) begin
            bump = 1'b1;
          end else if (q_tok.sign) begin
            neg_nxt   = q_tok.minus;
            bump      = 1'b1;
            phase_nxt = PH_SIGNED;
          end else begin
            do_start = 1'b1;
          end
        end
        PH_SIGNED: do_start = 1'b1;
        PH_AUTO_ZERO: begin
          if (q_tok.is_x) begin
            bump      = 1'b1;
            base_nxt  = BASE_HEX;
            phase_nxt = PH_DIGITS;
          end else begin
            do_digit = 1'b1;
            dig_base = BASE_OCT;
          end
        end
        PH_HEX_ZERO: begin
          if (q_tok.is_x) begin
            bump      = 1'b1;
            base_nxt  = BASE_HEX;
            phase_nxt = PH_DIGITS;
          end else begin
            // the leading zero was a real digit
            do_digit = 1'b1;
            dig_base = BASE_HEX;
            dig_seen = 1'b1;
          end
        end
        PH_DIGITS: do_digit = 1'b1;
        default: phase_nxt = PH_BLANK;
      endcase

      // first character after blanks and sign: pick the radix
      if (do_start) begin
        priority if (cfg_base == BASE_AUTO && q_tok.zero) begin
          bump      = 1'b1;
          phase_nxt = PH_AUTO_ZERO;
        end else if (cfg_base == BASE_HEX && q_tok.zero) begin
          bump      = 1'b1;
          phase_nxt = PH_HEX_ZERO;
        end else begin
          do_digit = 1'b1;
          dig_base = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
        end
      end

      if (do_digit) begin
        if (!q_tok.dig_ok || q_tok.dig >= dig_base) begin
          emit      = 1'b1;
          phase_nxt = PH_BLANK;
          acc_nxt   = '0;
          neg_nxt   = 1'b0;
          cnt_nxt   = '0;
          base_nxt  = '0;
          seen_nxt  = 1'b0;
        end else begin
          acc_nxt   = mac;
          seen_nxt  = 1'b1;
          bump      = 1'b1;
          base_nxt  = dig_base;
          phase_nxt = PH_DIGITS;
        end
      end

      if (bump && cnt_r != COUNT_LIMIT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r     <= dig_seen ? fin_val : '0;
      out_consumed_r  <= dig_seen ? cnt_r : '0;
      out_converted_r <= dig_seen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_converted_r, out_consumed_r, out_value_r};

  `T2I_ASSERT_IMP(a_blank_clean, phase_r == PH_BLANK, acc_r == '0 && !seen_r && !neg_r)
  `T2I_ASSERT_IMP(a_seen_in_digits, seen_r, phase_r == PH_DIGITS)
  `T2I_ASSERT_IMP(a_no_digit_zero, out_valid_r && !out_converted_r,
                  out_value_r == '0 && out_consumed_r == '0)
  `T2I_ASSERT_IMP(a_conv_counted, out_valid_r && out_converted_r, out_consumed_r != '0)
  `T2I_ASSERT_NXT(a_emit_loads, emit, out_valid_r)

endmodule

// ===== src/text_to_integer_parser.sv =====
// Text-to-integer parser, top level: configuration registers and the
// front end, token queue and back end. Depends on t2i_pkg and those modules.
//
// Usage: characters stream in on in_* (one byte per transfer in in_tdata).
// Leading spaces/tabs and one sign are skipped, an optional radix prefix is
// recognized, then digits accumulate as acc * base + digit. The first
// character that cannot continue the number ends it and yields one result
// on out_*: value (bits 63:0), consumed count (79:64), converted flag (80).
// Throughput: one character per cycle while the queue is not full; the
// accumulator's multiply-add by the 6-bit radix is combinational in the
// back end, ahead of the accumulator register. With the queue empty, the
// stopping character is written into the queue at its transfer, and the
// back end then steps it into the result register that drives out_*.
// Stall: a result waiting on out_tready holds the back end; the 4-entry
// queue keeps taking characters until it fills, then in_tready drops.
// Configuration: cfg_* writes register cfg_index (0 base, 1 signed mode,
// 2 wide result); cfg_ready is always high. Write only while idle.
// Reset (rst_n low, synchronous): parser returns to blank skipping, queue
// and result register empty, base 10, signed and 64-bit modes on.
module text_to_integer_parser import t2i_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,    // [7:0] character
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [63:0] value, [79:64] consumed, [80] converted, [87:81] zero
  output logic [DATA_OUT_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BASE_W-1:0]     cfg_data
);

  logic [BASE_W-1:0] base_r;
  logic              signed_r;
  logic              wide_r;

  logic              q_full, q_push, q_valid, q_pop;
  t2i_tok_t          push_tok, pop_tok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RESET;
      signed_r <= 1'b1;
      wide_r   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE: base_r   <= cfg_data;
        CFG_SIGNED_MODE: signed_r <= cfg_data[0];
        CFG_WIDE_RESULT: wide_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  t2i_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_tok     (push_tok)
  );

  t2i_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_tok  (pop_tok)
  );

  t2i_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_base   (base_r),
    .cfg_signed (signed_r),
    .cfg_wide   (wide_r),
    .q_valid    (q_valid),
    .q_tok      (pop_tok),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== test/text_to_integer_parser_tb.sv =====
// Self-checking testbench for text_to_integer_parser: streams characters with bursty
// input and a stalling output, predicts each parse result, checks every field.
// Depends on t2i_pkg and the text_to_integer_parser RTL.
`timescale 1ns / 100ps

module text_to_integer_parser_tb;
  import t2i_pkg::*;

  localparam int          IDLE_CYCLES  = 20;
  localparam longint      LIMIT_CYCLES = 2_000_000;
  localparam int          PHASE_CHARS  = 145;

  typedef struct packed {
    logic [ACC_W-1:0]   value;
    logic [COUNT_W-1:0] consumed;
    logic               converted;
  } parse_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_OUT_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BASE_W-1:0]     cfg_data = '0;

  text_to_integer_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // register shadow, updated when a write transfer completes
  logic [BASE_W-1:0] cur_base = BASE_RESET;
  logic              cur_signed = 1'b1;
  logic              cur_wide = 1'b1;

  // parser shadow
  t2i_phase_t        prs_phase = PH_BLANK;
  logic [ACC_W-1:0]  prs_acc = '0;
  logic              prs_neg = 1'b0;
  logic [COUNT_W-1:0] prs_count = '0;
  logic [BASE_W-1:0] prs_base = '0;
  logic              prs_seen = 1'b0;

  logic [CHAR_W-1:0] text_chars[$];
  parse_result_t     pending_results[$];
  int                chars_pushed = 0;
  int                chars_taken = 0;
  int                mismatches = 0;

  function automatic void bump_count();
    if (prs_count != COUNT_LIMIT) prs_count++;
  endfunction

  function automatic bit take_digit(input logic [CHAR_W-1:0] c, output parse_result_t r);
    int d;
    r = '0;
    d = 99;
    if (c >= CH_ZERO && c <= CH_NINE) d = int'(c - CH_ZERO);
    else if (c >= CH_A_LO && c <= CH_Z_LO) d = int'(c - CH_A_LO) + 10;
    else if (c >= CH_A_UP && c <= CH_Z_UP) d = int'(c - CH_A_UP) + 10;
    if (d >= int'(prs_base)) begin
      // stopping character: emit and start over
      r.value = prs_acc;
      if (prs_neg && cur_signed) r.value = -r.value;
      if (!cur_wide) r.value[ACC_W-1:32] = '0;
      r.consumed  = prs_count;
      r.converted = prs_seen;
      if (!prs_seen) begin
        r.value    = '0;
        r.consumed = '0;
      end
      prs_phase = PH_BLANK;
      prs_acc   = '0;
      prs_neg   = 1'b0;
      prs_count = '0;
      prs_base  = '0;
      prs_seen  = 1'b0;
      return 1'b1;
    end
    prs_acc   = prs_acc * ACC_W'(prs_base) + ACC_W'(d);
    prs_seen  = 1'b1;
    bump_count();
    prs_phase = PH_DIGITS;
    return 1'b0;
  endfunction

  // base register is sampled here, at the first character after blanks and sign
  function automatic bit take_start(input logic [CHAR_W-1:0] c, output parse_result_t r);
    r = '0;
    if (cur_base == BASE_AUTO) begin
      if (c == CH_ZERO) begin
        bump_count();
        prs_phase = PH_AUTO_ZERO;
        return 1'b0;
      end
      prs_base = BASE_DEC;
      return take_digit(c, r);
    end
    if (cur_base == BASE_HEX && c == CH_ZERO) begin
      bump_count();
      prs_phase = PH_HEX_ZERO;
      return 1'b0;
    end
    prs_base = cur_base;
    return take_digit(c, r);
  endfunction

  function automatic bit parse_char(input logic [CHAR_W-1:0] c, output parse_result_t r);
    r = '0;
    case (prs_phase)
      PH_SIGNED: return take_start(c, r);
      PH_AUTO_ZERO: begin
        if (c == CH_X_LO || c == CH_X_UP) begin
          prs_base = BASE_HEX;
          bump_count();
          prs_phase = PH_DIGITS;
          return 1'b0;
        end
        prs_base = BASE_OCT;
        return take_digit(c, r);
      end
      PH_HEX_ZERO: begin
        prs_base  = BASE_HEX;
        prs_phase = PH_DIGITS;
        if (c == CH_X_LO || c == CH_X_UP) begin
          bump_count();
          return 1'b0;
        end
        // the leading zero was a digit after all
        prs_seen = 1'b1;
        return take_digit(c, r);
      end
      PH_DIGITS: return take_digit(c, r);
      default: begin
        if (c == CH_SPACE || c == CH_TAB) begin
          bump_count();
          return 1'b0;
        end
        if (c == CH_MINUS || c == CH_PLUS) begin
          prs_neg = (c == CH_MINUS);
          bump_count();
          prs_phase = PH_SIGNED;
          return 1'b0;
        end
        return take_start(c, r);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                 input logic [ACC_W-1:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------- input driver ----------------
  int                burst_left = 0;
  int                gap_left = 0;
  logic              send_now;
  logic [CHAR_W-1:0] next_char;
  parse_result_t     char_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_char(in_tdata, char_res)) pending_results.push_back(char_res);
        chars_taken++;
      end
      if (!in_tvalid || in_tready) begin
        send_now = 1'b0;
        next_char = '0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_chars.size() != 0) begin
          send_now = 1'b1;
          next_char = text_chars.pop_front();
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        in_tvalid <= send_now;
        if (send_now) in_tdata <= next_char;
      end
    end
  end

  // ---------------- result monitor ----------------
  logic [31:0]   ready_pattern = '1;
  int            pattern_pos = 0;
  parse_result_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[ACC_W-1:0], '0);
      end else begin
        want_res = pending_results.pop_front();
        if (out_tdata[ACC_W-1:0] !== want_res.value)
          report_mismatch("value", out_tdata[ACC_W-1:0], want_res.value);
        if (out_tdata[ACC_W +: COUNT_W] !== want_res.consumed)
          report_mismatch("consumed", ACC_W'(out_tdata[ACC_W +: COUNT_W]),
                          ACC_W'(want_res.consumed));
        if (out_tdata[ACC_W+COUNT_W] !== want_res.converted)
          report_mismatch("converted", ACC_W'(out_tdata[ACC_W+COUNT_W]),
                          ACC_W'(want_res.converted));
      end
    end
    if (pattern_pos == 31) begin
      pattern_pos = 0;
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = $urandom;
        2: ready_pattern = $urandom | $urandom;
        default: ready_pattern = $urandom & $urandom;
      endcase
    end else begin
      pattern_pos++;
    end
    out_tready <= ready_pattern[pattern_pos];
  end

  // ---------------- stimulus ----------------
  task automatic push_char(input logic [CHAR_W-1:0] c);
    text_chars.push_back(c);
    chars_pushed++;
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    if (d < 10) return CHAR_W'(int'(CH_ZERO) + d);
    return CHAR_W'(int'($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + d - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] x_char();
    return $urandom_range(0, 1) ? CH_X_LO : CH_X_UP;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int base, input bit sgn, input bit wide);
    write_reg(CFG_NUMBER_BASE, BASE_W'(base));
    cur_base = BASE_W'(base);
    write_reg(CFG_SIGNED_MODE, BASE_W'(sgn));
    cur_signed = sgn;
    write_reg(CFG_WIDE_RESULT, BASE_W'(wide));
    cur_wide = wide;
    @(negedge clk);
  endtask

  // wait until every queued character is taken and every result is back
  task automatic drain();
    while (chars_taken != chars_pushed) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_stop();
    case ($urandom_range(0, 5))
      0: push_char(CH_SPACE);
      1: push_char(",");
      2: push_char(8'h00);
      3: push_char(CHAR_W'($urandom_range(128, 255)));
      4: push_char(";");
      default: push_char(CHAR_W'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic gen_number(input int radix);
    int kind;
    int dig_base;
    int ndig;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 3)) push_char(CHAR_W'($urandom_range(0, 255)));
    end else if (kind == 1) begin
      // sign, maybe a 0x prefix and maybe a minus, then a stop character
      push_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      if ($urandom_range(0, 1)) begin
        push_char(CH_ZERO);
        push_char(x_char());
      end
      if ($urandom_range(0, 2) == 0) push_char(CH_MINUS);
      push_stop();
    end else begin
      repeat ($urandom_range(0, 3)) push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      case ($urandom_range(0, 2))
        1: push_char(CH_PLUS);
        2: push_char(CH_MINUS);
        default: ;
      endcase
      dig_base = (radix > 36) ? 36 : radix;
      if (radix == int'(BASE_AUTO)) begin
        case ($urandom_range(0, 2))
          0: dig_base = 10;
          1: begin
            push_char(CH_ZERO);
            dig_base = 8;
          end
          default: begin
            push_char(CH_ZERO);
            push_char(x_char());
            dig_base = 16;
          end
        endcase
      end else if (radix == int'(BASE_HEX) && $urandom_range(0, 1)) begin
        push_char(CH_ZERO);
        push_char(x_char());
      end
      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int i = 0; i < ndig; i++) begin
        if (radix == int'(BASE_AUTO) && dig_base == 10 && i == 0)
          push_char(digit_char($urandom_range(1, 9)));
        else
          push_char(digit_char($urandom_range(0, dig_base - 1)));
      end
      push_stop();
    end
  endtask

  int phase_base[12]   = '{10, 0, 0, 16, 16, 2, 8, 36, 37, 63, 1, 7};
  bit phase_signed[12] = '{1, 1, 0, 0, 1, 1, 0, 1, 0, 1, 0, 1};
  bit phase_wide[12]   = '{1, 1, 0, 1, 0, 1, 0, 1, 1, 0, 1, 0};

  initial begin
    int start_count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: blanks, a minus sign, extreme bytes
    set_config(10, 1'b1, 1'b1);
    push_text(" \t-42,");
    push_char(8'hFF);
    push_char(8'h00);
    drain();
    // automatic base: hex prefix with minus ignored, lone zero, prefix without digit
    set_config(0, 1'b0, 1'b0);
    push_text("-0x1F;0;0xg");
    drain();
    // base 16: zero without x is a digit, prefix then no digit
    set_config(16, 1'b1, 1'b0);
    push_text("0a.-0Xz");
    drain();
    // base 1 takes only zeros
    set_config(1, 1'b1, 1'b1);
    push_text("00 ");
    drain();

    foreach (phase_base[p]) begin
      set_config(phase_base[p], phase_signed[p], phase_wide[p]);
      start_count = chars_pushed;
      while (chars_pushed - start_count < PHASE_CHARS) gen_number(phase_base[p]);
      // sometimes leave a number open across the register change
      if ($urandom_range(0, 1))
        repeat ($urandom_range(1, 3)) push_char(CHAR_W'(int'(CH_ZERO) + $urandom_range(0, 1)));
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/t2i_pkg.sv
src/t2i_front.sv
src/t2i_queue.sv
src/t2i_back.sv
src/text_to_integer_parser.sv
test/text_to_integer_parser_tb.sv
